/* sv/gbc_pkg.sv */
// Package for the GPIO bank controller: transfer payload types, pin-state
// entry type, action codes and pin constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

    localparam int unsigned PIN_COUNT = 73;
    localparam int unsigned PIN_W     = 7;
    localparam int unsigned MEM_AW    = $clog2(PIN_COUNT);

    localparam logic [2:0] ACT_RD_LEVEL = 3'd0;
    localparam logic [2:0] ACT_RD_DIR   = 3'd1;
    localparam logic [2:0] ACT_RD_MODE  = 3'd2;
    localparam logic [2:0] ACT_SET_DIR  = 3'd3;
    localparam logic [2:0] ACT_SET_LVL  = 3'd4;

    localparam logic [3:0] MODE_OUTPUT  = 4'd8;

    typedef struct packed {
        logic [2:0]       action;
        logic [PIN_W-1:0] pin;
        logic             value;
        logic             pad_level;
    } t_gbc_in;

    typedef struct packed {
        logic       read_bit;
        logic [3:0] pin_mode;
        logic       accepted;
    } t_gbc_out;

    // one memory word per pin
    typedef struct packed {
        logic dir;
        logic latch;
    } t_gbc_entry;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        t_gbc_entry        data;
    } t_gbc_mem_wr;

endpackage

`default_nettype wire

/* sv/gbc_pin_mem.sv */
// Pin-state memory: one direction/latch entry per pin, synchronous read with
// registered read data. Per-entry valid bits make unwritten entries read as zero.
`timescale 1ns / 1ps
`default_nettype none

module gbc_pin_mem (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_rd_en,
    input  wire [gbc_pkg::MEM_AW-1:0]  i_rd_addr,
    output gbc_pkg::t_gbc_entry        o_rd_data,
    input  gbc_pkg::t_gbc_mem_wr       i_wr
);
    import gbc_pkg::*;

    t_gbc_entry               r_mem [PIN_COUNT];
    logic [PIN_COUNT-1:0]     r_vld;
    t_gbc_entry               r_rd_data;
    logic                     r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : t_gbc_entry'('0);

endmodule

`default_nettype wire

/* sv/gbc_mode_dec.sv */
// Pin mux mode decoder: picks the pin group's field from the mode word and
// applies the GPIO-select rule. Uses gbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbc_mode_dec (
    input  wire [gbc_pkg::PIN_W-1:0] i_pin,
    input  wire [31:0]               i_mux_word,
    input  wire                      i_dir,
    output logic [3:0]               o_mode
);
    import gbc_pkg::*;

    logic [2:0] m;
    logic       gpio;

    always_comb begin
        m    = 3'd0;
        gpio = 1'b0;
        priority if (i_pin == 7'd0) begin
            gpio = 1'b1;
        end else if (i_pin <= 7'd2) begin
            m    = {2'b0, i_mux_word[0]};
            gpio = (m == 3'd1);
        end else if ((i_pin <= 7'd6) || (i_pin >= 7'd37 && i_pin <= 7'd39)) begin
            m    = {1'b0, i_mux_word[12:11]};
            gpio = m[0] || (i_pin == 7'd38) || (i_pin == 7'd39)
                   || (i_pin == 7'd37 && m == 3'd3);
        end else if (i_pin <= 7'd14) begin
            m    = i_mux_word[4:2];
            gpio = (m == 3'd7) || (i_pin <= 7'd10 && m == 3'd4)
                   || (i_pin >= 7'd11 && m >= 3'd5);
        end else if (i_pin <= 7'd16) begin
            m    = {2'b0, i_mux_word[5]};
            gpio = (m == 3'd1);
        end else if (i_pin == 7'd17) begin
            m    = {1'b0, i_mux_word[22:21]};
            gpio = (m == 3'd2);
        end else if (i_pin <= 7'd21) begin
            m    = {2'b0, i_mux_word[20]};
            gpio = (m == 3'd1);
        end else if (i_pin <= 7'd23) begin
            m    = {1'b0, i_mux_word[8:7]};
            gpio = (m == 3'd2);
        end else if (i_pin <= 7'd35) begin
            m    = {2'b0, i_mux_word[9]};
            gpio = (m == 3'd1);
        end else if (i_pin == 7'd36) begin
            m    = {1'b0, i_mux_word[16:15]};
            gpio = (m == 3'd2);
        end else if (i_pin <= 7'd44) begin
            m    = {2'b0, i_mux_word[15]};
            gpio = (m == 3'd1);
        end else if (i_pin <= 7'd59) begin
            m    = {1'b0, i_mux_word[16:15]};
            gpio = (m == 3'd2);
        end else if (i_pin <= 7'd71) begin
            m    = {2'b0, i_mux_word[10]};
            gpio = (m == 3'd1);
        end else begin
            m    = {2'b0, i_mux_word[13]};
            gpio = (m == 3'd1);
        end
    end

    assign o_mode = (gpio && i_dir) ? MODE_OUTPUT : {1'b0, m};

endmodule

`default_nettype wire

/* sv/gpio_bank_controller_with_pinmux_unit.sv */
// GPIO bank controller top level: input/output transfer control, mode word
// register, result logic. Uses gbc_pkg, gbc_pin_mem and gbc_mode_dec.
//
// Controller for 73 GPIO pins (banks of 24, 16, 32 and 1) holding a direction
// bit and output latch per pin, plus pin-mux mode readback from a 32-bit mode
// word. Each transfer in yields exactly one transfer out. For each item, the
// pin's entry is read from the pin-state memory in the accept cycle, then the
// result is formed and any update written back once the output register is
// free; a new item is taken only once that write-back is done. The result
// sits in an output register, so the next item can be taken while it waits.
// Pin numbers of 73 and above are refused (accepted = 0). Write the mode word
// only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module gpio_bank_controller_with_pinmux_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [31:0]         i_cfg_wdata,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  gbc_pkg::t_gbc_in   i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output gbc_pkg::t_gbc_out  o_out_item
);
    import gbc_pkg::*;

    logic [31:0]  r_mux_word;
    logic         r_s1_valid;
    logic         n_s1_valid;
    t_gbc_in      r_s1_item;
    logic         r_out_valid;
    logic         n_out_valid;
    t_gbc_out     r_out_item;
    t_gbc_out     n_out_item;

    logic         in_xfer;
    logic         out_free;
    logic         s1_done;
    logic         in_pin_ok;
    logic         s1_pin_ok;
    t_gbc_entry   rd_entry;
    t_gbc_mem_wr  mem_wr;
    logic [3:0]   dec_mode;
    logic [MEM_AW-1:0] s1_addr;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign in_pin_ok = (i_in_item.pin < PIN_W'(PIN_COUNT));
    assign s1_pin_ok = (r_s1_item.pin < PIN_W'(PIN_COUNT));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign s1_done   = r_s1_valid && out_free;
    assign s1_addr   = MEM_AW'(r_s1_item.pin);

    // one item in flight: stall covers the read-to-write-back window
    assign o_in_stall = r_s1_valid;

    gbc_pin_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer && in_pin_ok),
        .i_rd_addr (MEM_AW'(i_in_item.pin)),
        .o_rd_data (rd_entry),
        .i_wr      (mem_wr)
    );

    gbc_mode_dec u_dec (
        .i_pin      (r_s1_item.pin),
        .i_mux_word (r_mux_word),
        .i_dir      (rd_entry.dir),
        .o_mode     (dec_mode)
    );

    always_comb begin
        mem_wr      = '0;
        mem_wr.addr = s1_addr;
        mem_wr.data = rd_entry;
        n_out_item  = '0;
        if (r_s1_item.action <= ACT_SET_LVL && s1_pin_ok) begin
            n_out_item.accepted = 1'b1;
            unique case (r_s1_item.action)
                ACT_RD_LEVEL: n_out_item.read_bit = rd_entry.dir ? rd_entry.latch
                                                                 : r_s1_item.pad_level;
                ACT_RD_DIR:   n_out_item.read_bit = rd_entry.dir;
                ACT_RD_MODE:  n_out_item.pin_mode = dec_mode;
                ACT_SET_DIR: begin
                    mem_wr.en       = s1_done;
                    mem_wr.data.dir = r_s1_item.value;
                end
                default: begin
                    mem_wr.en         = s1_done;
                    mem_wr.data.latch = r_s1_item.value;
                end
            endcase
        end
    end

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (s1_done) begin
            n_s1_valid  = 1'b0;
            n_out_valid = 1'b1;
        end
        if (in_xfer) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mux_word  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mux_word <= i_cfg_wdata;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_item;
        end
        if (s1_done) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_accept_loads_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_valid)
        else $error("accepted item not held in stage");

    a_s1_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_done |=> o_out_valid && !r_s1_valid)
        else $error("finished item did not reach output register");

    a_refused_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.accepted) |->
            (o_out_item.read_bit == 1'b0 && o_out_item.pin_mode == 4'd0))
        else $error("refused item returned data");

    a_write_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr.en |-> (r_s1_item.pin < PIN_W'(PIN_COUNT) && !in_xfer))
        else $error("write-back to bad pin or overlapping accept");

endmodule

`default_nettype wire
